FILE: rtl/bged_pkg.sv
// bged_pkg: shared types, gesture codes and slot helpers for the button
// and encoder gesture detector. No dependencies.

package bged_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned TURN_W   = 8;
    localparam int unsigned CODE_W   = 4;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd500;

    // pending result slots of one frame, lowest slot goes out first
    localparam int unsigned SLOTS  = 10;
    localparam int unsigned SLOT_W = 4;
    localparam logic [SLOT_W-1:0] SLOT_ENTER  = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_EXIT   = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_TAP    = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_A_PRS  = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_A_REL  = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_B_PRS  = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_B_REL  = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_TURN_A = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_TURN_B = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_NONE   = 4'd9;

    typedef enum logic [CODE_W-1:0] {
        GEST_NONE         = 4'd0,
        GEST_SHIFT_ENTER  = 4'd1,
        GEST_SHIFT_EXIT   = 4'd2,
        GEST_TAP          = 4'd3,
        GEST_A_PRESS      = 4'd4,
        GEST_A_RELEASE    = 4'd5,
        GEST_B_PRESS      = 4'd6,
        GEST_B_RELEASE    = 4'd7,
        GEST_TURN_A       = 4'd8,
        GEST_TURN_B       = 4'd9,
        GEST_SHIFT_TURN_A = 4'd10,
        GEST_SHIFT_TURN_B = 4'd11
    } t_gesture;

    typedef struct packed {
        logic [TIME_W-1:0]        time_ms;
        logic                     center_level;
        logic                     enc_a_button_level;
        logic                     center_rise;
        logic                     center_fall;
        logic                     a_rise;
        logic                     a_fall;
        logic                     b_rise;
        logic                     b_fall;
        logic signed [TURN_W-1:0] turn_a;
        logic signed [TURN_W-1:0] turn_b;
    } t_frame;

    typedef struct packed {
        logic [TIME_W-1:0] press_time;
        logic              long_fired;
        logic              shift_mode;
    } t_state;

    typedef struct packed {
        logic [SLOTS-1:0] pend;
        t_state           next;
    } t_eval;

    function automatic t_gesture slot_code(input logic [SLOT_W-1:0] slot,
                                           input logic shift);
        t_gesture code;
        unique case (slot)
            SLOT_ENTER:  code = GEST_SHIFT_ENTER;
            SLOT_EXIT:   code = GEST_SHIFT_EXIT;
            SLOT_TAP:    code = GEST_TAP;
            SLOT_A_PRS:  code = GEST_A_PRESS;
            SLOT_A_REL:  code = GEST_A_RELEASE;
            SLOT_B_PRS:  code = GEST_B_PRESS;
            SLOT_B_REL:  code = GEST_B_RELEASE;
            SLOT_TURN_A: code = shift ? GEST_SHIFT_TURN_A : GEST_TURN_A;
            SLOT_TURN_B: code = shift ? GEST_SHIFT_TURN_B : GEST_TURN_B;
            default:     code = GEST_NONE;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/bged_in_if.sv
// bged_in_if: input frame channel, valid/ready with one frame per beat.
// Uses bged_pkg widths.

interface bged_in_if;
    import bged_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        time_ms;
    logic                     center_level;
    logic                     enc_a_button_level;
    logic                     center_rise;
    logic                     center_fall;
    logic                     a_rise;
    logic                     a_fall;
    logic                     b_rise;
    logic                     b_fall;
    logic signed [TURN_W-1:0] turn_a;
    logic signed [TURN_W-1:0] turn_b;

    modport source (
        output valid, time_ms, center_level, enc_a_button_level, center_rise,
               center_fall, a_rise, a_fall, b_rise, b_fall, turn_a, turn_b,
        input  ready
    );

    modport sink (
        input  valid, time_ms, center_level, enc_a_button_level, center_rise,
               center_fall, a_rise, a_fall, b_rise, b_fall, turn_a, turn_b,
        output ready
    );
endinterface

FILE: rtl/bged_out_if.sv
// bged_out_if: gesture result channel, valid/ready with one result per beat.
// Uses bged_pkg widths.

interface bged_out_if;
    import bged_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CODE_W-1:0]        gesture;
    logic signed [TURN_W-1:0] amount;
    logic                     shift_level;
    logic                     last;

    modport source (
        output valid, gesture, amount, shift_level, last,
        input  ready
    );

    modport sink (
        input  valid, gesture, amount, shift_level, last,
        output ready
    );
endinterface

FILE: rtl/bged_eval.sv
// bged_eval: per-frame gesture evaluation, gives the pending result slots
// and the next press/shift state. Depends on bged_pkg.

module bged_eval (
    input  bged_pkg::t_frame          i_frame,
    input  bged_pkg::t_state          i_state,
    input  logic [bged_pkg::HOLD_W-1:0] i_hold,
    output bged_pkg::t_eval           o_eval
);
    import bged_pkg::*;

    logic [TIME_W-1:0] press_time;
    logic [TIME_W-1:0] elapsed;
    logic              fired;
    logic              enter;
    logic              fired_after;
    logic              shift;
    logic              do_exit;
    logic              do_tap;
    logic [SLOTS-1:0]  pend;

    always_comb begin
        press_time = i_frame.center_rise ? i_frame.time_ms : i_state.press_time;
        fired      = i_frame.center_rise ? 1'b0 : i_state.long_fired;
        elapsed    = i_frame.time_ms - press_time;
        enter      = i_frame.center_level && !i_frame.enc_a_button_level && !fired
                     && (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, i_hold});

        fired_after = fired | enter;
        shift       = i_state.shift_mode | enter;
        do_exit     = i_frame.center_fall & fired_after;
        do_tap      = i_frame.center_fall & ~fired_after;
        if (do_exit) begin
            shift       = 1'b0;
            fired_after = 1'b0;
        end

        pend              = '0;
        pend[SLOT_ENTER]  = enter;
        pend[SLOT_EXIT]   = do_exit;
        pend[SLOT_TAP]    = do_tap;
        pend[SLOT_A_PRS]  = i_frame.a_rise;
        pend[SLOT_A_REL]  = i_frame.a_fall;
        pend[SLOT_B_PRS]  = i_frame.b_rise;
        pend[SLOT_B_REL]  = i_frame.b_fall;
        pend[SLOT_TURN_A] = (i_frame.turn_a != '0);
        pend[SLOT_TURN_B] = (i_frame.turn_b != '0);
        // quiet frame still gives one result
        pend[SLOT_NONE]   = (pend == '0);

        o_eval.pend            = pend;
        o_eval.next.press_time = press_time;
        o_eval.next.long_fired = fired_after;
        o_eval.next.shift_mode = shift;
    end
endmodule

FILE: rtl/button_encoder_gesture_detector_top.sv
// button_encoder_gesture_detector_top: frame register, gesture evaluation,
// per-frame result drain and output register. Depends on bged_pkg,
// bged_in_if, bged_out_if and bged_eval.
//
//   channel   dir  beat                            port
//   frame     in   one input frame                 i_frame (bged_in_if.sink)
//   gesture   out  one gesture result              o_gest  (bged_out_if.source)
//   config    in   hold_threshold_ms write         i_cfg_we / i_cfg_wdata
//
// a frame gives 1 to 8 results, one result per cycle through the output
// register without an output stall; a result passes the frame register,
// drain stage, output register; single-result frames also go one per cycle.
// reset is synchronous: state clears and the threshold returns to 500 ms.
// a stall on the output holds the drain stage, then the frame register,
// then input ready.

module button_encoder_gesture_detector_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bged_pkg::HOLD_W-1:0] i_cfg_wdata,
    bged_in_if.sink                     i_frame,
    bged_out_if.source                  o_gest
);
    import bged_pkg::*;

    // control
    logic                     r_in_valid;
    logic                     r_dr_valid;
    logic [SLOTS-1:0]         r_mask;
    logic                     r_out_valid;
    t_state                   r_state;
    logic [HOLD_W-1:0]        r_hold;
    // payload
    t_frame                   r_in;
    logic signed [TURN_W-1:0] r_dr_turn_a;
    logic signed [TURN_W-1:0] r_dr_turn_b;
    logic                     r_dr_shift;
    t_gesture                 r_gesture;
    logic signed [TURN_W-1:0] r_amount;
    logic                     r_shift;
    logic                     r_last;

    t_eval             eval;
    logic              out_free;
    logic              out_load;
    logic              dr_free;
    logic              move;
    logic              in_ready;
    logic [SLOTS-1:0]  rest;
    logic [SLOT_W-1:0] pick;

    bged_eval u_eval (
        .i_frame (r_in),
        .i_state (r_state),
        .i_hold  (r_hold),
        .o_eval  (eval)
    );

    always_comb begin
        pick = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick = SLOT_W'(i);
            end
        end
    end

    // clear lowest pending slot
    assign rest     = r_mask & (r_mask - 1'b1);
    assign out_free = !r_out_valid || o_gest.ready;
    assign out_load = r_dr_valid && out_free;
    assign dr_free  = !r_dr_valid || (out_load && (rest == '0));
    assign move     = r_in_valid && dr_free;
    assign in_ready = !r_in_valid || move;

    assign i_frame.ready      = in_ready;
    assign o_gest.valid       = r_out_valid;
    assign o_gest.gesture     = r_gesture;
    assign o_gest.amount      = r_amount;
    assign o_gest.shift_level = r_shift;
    assign o_gest.last        = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_dr_valid  <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_hold      <= HOLD_RESET;
        end else begin
            if (i_cfg_we) begin
                r_hold <= i_cfg_wdata;
            end
            if (in_ready) begin
                r_in_valid <= i_frame.valid;
            end
            if (move) begin
                r_dr_valid <= 1'b1;
                r_mask     <= eval.pend;
                r_state    <= eval.next;
            end else if (out_load) begin
                r_mask <= rest;
                if (rest == '0) begin
                    r_dr_valid <= 1'b0;
                end
            end
            if (out_free) begin
                r_out_valid <= r_dr_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_frame.valid) begin
            r_in.time_ms            <= i_frame.time_ms;
            r_in.center_level       <= i_frame.center_level;
            r_in.enc_a_button_level <= i_frame.enc_a_button_level;
            r_in.center_rise        <= i_frame.center_rise;
            r_in.center_fall        <= i_frame.center_fall;
            r_in.a_rise             <= i_frame.a_rise;
            r_in.a_fall             <= i_frame.a_fall;
            r_in.b_rise             <= i_frame.b_rise;
            r_in.b_fall             <= i_frame.b_fall;
            r_in.turn_a             <= i_frame.turn_a;
            r_in.turn_b             <= i_frame.turn_b;
        end
        if (move) begin
            r_dr_turn_a <= r_in.turn_a;
            r_dr_turn_b <= r_in.turn_b;
            r_dr_shift  <= eval.next.shift_mode;
        end
        if (out_load) begin
            r_gesture <= slot_code(pick, r_dr_shift);
            r_shift   <= r_dr_shift;
            r_last    <= (rest == '0);
            if (pick == SLOT_TURN_A) begin
                r_amount <= r_dr_turn_a;
            end else if (pick == SLOT_TURN_B) begin
                r_amount <= r_dr_turn_b;
            end else begin
                r_amount <= '0;
            end
        end
    end

    a_drain_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dr_valid |-> (r_mask != '0))
        else $error("drain stage valid with no pending slot");

    a_shift_turn_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_gesture == GEST_SHIFT_TURN_A ||
                         r_gesture == GEST_SHIFT_TURN_B)) |-> r_shift)
        else $error("shift turn sent while shift level low");

    a_plain_turn_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_gesture == GEST_TURN_A ||
                         r_gesture == GEST_TURN_B)) |-> !r_shift)
        else $error("plain turn sent while shift level high");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_gesture == GEST_NONE) |-> (r_last && r_amount == '0))
        else $error("quiet frame result not alone");

endmodule
